@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/kqt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kqt_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int OUT_IDX_W   = 7;
	localparam int OUT_CNT_W   = 8;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EXISTS    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] part_key;
		logic signed [DATA_W-1:0] amount;
	} req_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [OUT_IDX_W-1:0]     entry_index;
		logic signed [DATA_W-1:0] quantity;
		logic [OUT_CNT_W-1:0]     entry_count;
	} rsp_word_t;

	// how an operation ends
	typedef enum logic [2:0] {
		RK_FULL,
		RK_EXISTS,
		RK_MISS,
		RK_INSERT,
		RK_LOOKUP,
		RK_UPDATE
	} res_kind_t;

	typedef struct packed {
		logic      start;
		logic      scan;
		logic      qread;
		logic      finish;
		res_kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op_ins;
		logic op_upd;
		logic full;
		logic empty;
		logic hit;
		logic last;
		logic can_load;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/kqt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kqt_ctrl import kqt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_QREAD,
		S_FINISH
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      ins_full;

	assign ins_full = stat.op_ins && stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RK_MISS;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ins_full) begin
						kind_q  <= RK_FULL;
						state_q <= S_FINISH;
					end else if (stat.hit) begin
						if (stat.op_ins) begin
							kind_q  <= RK_EXISTS;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_QREAD;
						end
					end else if (stat.empty || stat.last) begin
						kind_q  <= stat.op_ins ? RK_INSERT : RK_MISS;
						state_q <= S_FINISH;
					end
				end
				S_QREAD: begin
					kind_q  <= stat.op_upd ? RK_UPDATE : RK_LOOKUP;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (stat.can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall  = (state_q != S_IDLE);
	assign cmd.start  = (state_q == S_IDLE) && req_valid;
	assign cmd.scan   = (state_q == S_SCAN) && !ins_full && !stat.hit
		&& !stat.empty && !stat.last;
	assign cmd.qread  = (state_q == S_QREAD);
	assign cmd.finish = (state_q == S_FINISH) && stat.can_load;
	assign cmd.kind   = kind_q;

endmodule

`default_nettype wire

@@ rtl/kqt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kqt_dp import kqt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_word_t req_word,
	input  wire ctrl_cmd_t cmd,
	output dp_stat_t       stat,
	input  wire logic      rsp_stall,
	output logic           rsp_valid,
	output rsp_word_t      rsp_word
);

	logic [DATA_W-1:0] key_mem [TABLE_DEPTH];
	logic [DATA_W-1:0] qty_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  cmp_idx_q;
	logic              cmp_vld_q;
	logic              rsp_vld_q;
	logic [1:0]        op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] amt_q;
	logic [DATA_W-1:0] key_rd_q;
	logic [DATA_W-1:0] qty_rd_q;
	rsp_word_t         rsp_q;

	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] sat_sum;
	logic [CNT_W-1:0]  res_idx;
	logic [CNT_W-1:0]  res_cnt;
	logic [31:0]       idx_wide;
	logic [31:0]       cnt_wide;
	rsp_word_t         rsp_d;
	logic              do_ins;
	logic              do_upd;

	// saturating add of stored quantity and change
	assign sum     = {qty_rd_q[DATA_W-1], qty_rd_q} + {amt_q[DATA_W-1], amt_q};
	assign sat_sum = (sum[DATA_W] != sum[DATA_W-1])
		? (sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}})
		: sum[DATA_W-1:0];

	assign do_ins = cmd.finish && (cmd.kind == RK_INSERT);
	assign do_upd = cmd.finish && (cmd.kind == RK_UPDATE);

	assign stat.op_ins   = (op_q == OP_INSERT);
	assign stat.op_upd   = (op_q == OP_UPDATE);
	assign stat.full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.hit      = cmp_vld_q && (key_rd_q == key_q);
	assign stat.last     = cmp_vld_q && (cmp_idx_q == count_q - CNT_W'(1));
	assign stat.can_load = !rsp_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				scan_q    <= '0;
				cmp_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				scan_q    <= scan_q + CNT_W'(1);
				cmp_vld_q <= 1'b1;
			end
			if (cmd.finish) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && !rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= req_word.operation;
			key_q <= req_word.part_key;
			amt_q <= req_word.amount;
		end
		if (cmd.scan) begin
			cmp_idx_q <= scan_q;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	// key memory: one read per scan step, write on insert
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			key_rd_q <= key_mem[scan_q[IDX_W-1:0]];
		end
		if (do_ins) begin
			key_mem[count_q[IDX_W-1:0]] <= key_q;
		end
	end

	// quantity memory
	always_ff @(posedge clk) begin
		if (cmd.qread) begin
			qty_rd_q <= qty_mem[cmp_idx_q[IDX_W-1:0]];
		end
		if (do_ins) begin
			qty_mem[count_q[IDX_W-1:0]] <= amt_q;
		end else if (do_upd) begin
			qty_mem[cmp_idx_q[IDX_W-1:0]] <= sat_sum;
		end
	end

	always_comb begin
		rsp_d    = '0;
		res_idx  = '0;
		res_cnt  = count_q;
		case (cmd.kind)
			RK_FULL: begin
				rsp_d.status = ST_FULL;
			end
			RK_EXISTS: begin
				rsp_d.status = ST_EXISTS;
			end
			RK_MISS: begin
				rsp_d.status = ST_NOT_FOUND;
			end
			RK_INSERT: begin
				rsp_d.status   = ST_OK;
				res_idx        = count_q;
				rsp_d.quantity = amt_q;
				res_cnt        = count_q + CNT_W'(1);
			end
			RK_LOOKUP: begin
				rsp_d.status   = ST_OK;
				res_idx        = cmp_idx_q;
				rsp_d.quantity = qty_rd_q;
			end
			RK_UPDATE: begin
				rsp_d.status   = ST_OK;
				res_idx        = cmp_idx_q;
				rsp_d.quantity = sat_sum;
			end
			default: begin
				rsp_d.status = ST_NOT_FOUND;
			end
		endcase
		idx_wide          = 32'(res_idx);
		cnt_wide          = 32'(res_cnt);
		rsp_d.entry_index = idx_wide[OUT_IDX_W-1:0];
		rsp_d.entry_count = cnt_wide[OUT_CNT_W-1:0];
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_word  = rsp_q;

	`ASSERT_IMPL(a_cnt_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`ASSERT_IMPL(a_cmp_range, cmp_vld_q, cmp_idx_q < count_q)
	`ASSERT_IMPL(a_no_overwrite, cmd.finish, !rsp_vld_q || !rsp_stall)
	`ASSERT_NEXT(a_ins_cnt, do_ins, count_q == $past(count_q) + CNT_W'(1))

endmodule

`default_nettype wire

@@ rtl/keyed_quantity_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake              | word
// req     | in        | req_valid / req_stall  | operation, part_key, amount
// rsp     | out       | rsp_valid / rsp_stall  | status, entry_index, quantity, entry_count
//
// one word in at a time; the search compares stored keys in turn, up to the entry count
// the search reads one stored key per cycle from the key memory
// insert into a full table ends without a key search; a lookup or update hit adds a state
// for the quantity read, a duplicate key on insert does not
// reset clears the entry count and all control; the stores are not cleared
// the result sits in an output register; a new word is taken while it waits on rsp_stall

module keyed_quantity_table_core import kqt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req_word,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp_word
);

	// commands from the sequencer, status back from the table datapath
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: accept, scan keys, read quantity on hit, load result
	kqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// key and quantity memories, count, compare, saturating add, result register
	kqt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_word  (rsp_word)
	);

endmodule

`default_nettype wire
